// ----- design/mlp_pkg.sv -----
// Shared constants and types for the two-layer perceptron block.
// Holds input opcodes, issue codes of the MAC pipeline and the
// control struct passed from the sequencer to the datapath.
package mlp_pkg;

  localparam int VAL_W  = 16;
  localparam int Q_FRAC = 8;

  localparam logic [2:0] OP_W1     = 3'd0;
  localparam logic [2:0] OP_B1     = 3'd1;
  localparam logic [2:0] OP_W2     = 3'd2;
  localparam logic [2:0] OP_B2     = 3'd3;
  localparam logic [2:0] OP_SAMPLE = 3'd4;

  localparam logic [1:0] ISS_NONE = 2'd0;
  localparam logic [1:0] ISS_BIAS = 2'd1;
  localparam logic [1:0] ISS_MAC  = 2'd2;

  typedef struct packed {
    logic [1:0] issue;
    logic       layer2;
    logic       wr_hid;
    logic       emit;
    logic       clr_sat;
    logic       last;
  } ctrl_t;

endpackage

// ----- design/mlp_useq.sv -----
// Microcoded sequencer: control store, step counter, loop counters.
// Drives the datapath through mlp_pkg::ctrl_t and the table addresses.
// Depends on mlp_pkg.
module mlp_useq #(
  parameter int IN_MAX  = 64,
  parameter int HID_MAX = 64,
  parameter int OUT_MAX = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                trig,
  input  logic [IN_AW-1:0]    in_last,
  input  logic [HID_AW-1:0]   hid_last,
  input  logic [OUT_AW-1:0]   out_last,
  input  logic                out_free,
  output logic                idle,
  output mlp_pkg::ctrl_t      ctrl,
  output logic [CNT_W-1:0]    inner,
  output logic [CNT_W-1:0]    outer,
  output logic [WA_W-1:0]     waddr
);

  localparam int IN_AW  = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int HID_AW = (HID_MAX > 1) ? $clog2(HID_MAX) : 1;
  localparam int OUT_AW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int CNT_A  = (IN_AW > HID_AW) ? IN_AW : HID_AW;
  localparam int CNT_W  = (CNT_A > OUT_AW) ? CNT_A : OUT_AW;
  localparam int W1_AW  = (IN_MAX * HID_MAX > 1) ? $clog2(IN_MAX * HID_MAX) : 1;
  localparam int W2_AW  = (OUT_MAX * HID_MAX > 1) ? $clog2(OUT_MAX * HID_MAX) : 1;
  localparam int WA_W   = (W1_AW > W2_AW) ? W1_AW : W2_AW;

  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] S_IDLE = 4'd0;
  localparam logic [PC_W-1:0] S_B1   = 4'd1;
  localparam logic [PC_W-1:0] S_M1   = 4'd2;
  localparam logic [PC_W-1:0] S_D1A  = 4'd3;
  localparam logic [PC_W-1:0] S_D1B  = 4'd4;
  localparam logic [PC_W-1:0] S_HID  = 4'd5;
  localparam logic [PC_W-1:0] S_B2   = 4'd6;
  localparam logic [PC_W-1:0] S_M2   = 4'd7;
  localparam logic [PC_W-1:0] S_D2A  = 4'd8;
  localparam logic [PC_W-1:0] S_D2B  = 4'd9;
  localparam logic [PC_W-1:0] S_OUT  = 4'd10;

  localparam logic [2:0] C_NEXT  = 3'd0;
  localparam logic [2:0] C_TRIG  = 3'd1;
  localparam logic [2:0] C_LOOP  = 3'd2;
  localparam logic [2:0] C_OUTER = 3'd3;
  localparam logic [2:0] C_EMIT  = 3'd4;

  typedef struct packed {
    mlp_pkg::ctrl_t  ctrl;
    logic [2:0]      cond;
    logic [PC_W-1:0] tgt_a;
    logic [PC_W-1:0] tgt_b;
  } cw_t;

  function automatic cw_t ucode(input logic [PC_W-1:0] step);
    cw_t w;
    w = '0;
    unique case (step)
      S_IDLE: begin
        w.ctrl.clr_sat = 1'b1;
        w.cond         = C_TRIG;
      end
      S_B1: begin
        w.ctrl.issue = mlp_pkg::ISS_BIAS;
        w.cond       = C_NEXT;
      end
      S_M1: begin
        w.ctrl.issue = mlp_pkg::ISS_MAC;
        w.cond       = C_LOOP;
      end
      S_D1A, S_D1B: begin
        w.cond = C_NEXT;
      end
      S_HID: begin
        w.ctrl.wr_hid = 1'b1;
        w.cond        = C_OUTER;
        w.tgt_a       = S_B2;
        w.tgt_b       = S_B1;
      end
      S_B2: begin
        w.ctrl.issue  = mlp_pkg::ISS_BIAS;
        w.ctrl.layer2 = 1'b1;
        w.cond        = C_NEXT;
      end
      S_M2: begin
        w.ctrl.issue  = mlp_pkg::ISS_MAC;
        w.ctrl.layer2 = 1'b1;
        w.cond        = C_LOOP;
      end
      S_D2A, S_D2B: begin
        w.ctrl.layer2 = 1'b1;
        w.cond        = C_NEXT;
      end
      S_OUT: begin
        w.ctrl.layer2 = 1'b1;
        w.ctrl.emit   = 1'b1;
        w.cond        = C_EMIT;
        w.tgt_a       = S_IDLE;
        w.tgt_b       = S_B2;
      end
      default: begin
        w.cond  = C_OUTER;
        w.tgt_a = S_IDLE;
        w.tgt_b = S_IDLE;
      end
    endcase
    return w;
  endfunction

  logic [PC_W-1:0]  pc;
  logic [PC_W-1:0]  pc_next;
  logic [CNT_W-1:0] inner_next;
  logic [CNT_W-1:0] outer_next;
  logic [WA_W-1:0]  waddr_next;
  cw_t              cw;
  logic             inner_last;
  logic             outer_last;
  logic             adv;

  always_comb begin
    cw         = ucode(pc);
    inner_last = cw.ctrl.layer2 ? (inner == CNT_W'(hid_last)) : (inner == CNT_W'(in_last));
    outer_last = cw.ctrl.layer2 ? (outer == CNT_W'(out_last)) : (outer == CNT_W'(hid_last));
    adv        = (cw.cond == C_OUTER) || ((cw.cond == C_EMIT) && out_free);

    unique case (cw.cond)
      C_NEXT:  pc_next = pc + PC_W'(1);
      C_TRIG:  pc_next = trig ? pc + PC_W'(1) : pc;
      C_LOOP:  pc_next = inner_last ? pc + PC_W'(1) : pc;
      C_OUTER: pc_next = outer_last ? cw.tgt_a : cw.tgt_b;
      C_EMIT:  pc_next = !out_free ? pc : (outer_last ? cw.tgt_a : cw.tgt_b);
      default: pc_next = S_IDLE;
    endcase

    inner_next = (cw.ctrl.issue == mlp_pkg::ISS_MAC) ? inner + CNT_W'(1) : '0;

    if (adv) begin
      outer_next = outer_last ? '0 : outer + CNT_W'(1);
    end else begin
      outer_next = outer;
    end

    if (cw.ctrl.issue == mlp_pkg::ISS_MAC) begin
      waddr_next = waddr + WA_W'(1);
    end else if (adv && outer_last) begin
      waddr_next = '0;
    end else begin
      waddr_next = waddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= S_IDLE;
      inner <= '0;
      outer <= '0;
      waddr <= '0;
    end else begin
      pc    <= pc_next;
      inner <= inner_next;
      outer <= outer_next;
      waddr <= waddr_next;
    end
  end

  always_comb begin
    ctrl      = cw.ctrl;
    ctrl.last = outer_last;
    idle      = (pc == S_IDLE);
  end

  a_trig_idle: assert property (@(posedge clk) disable iff (rst) trig |-> pc == S_IDLE)
    else $error("sample trigger outside idle step");
  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= S_OUT)
    else $error("step counter beyond program");
  a_bias_inner: assert property (@(posedge clk) disable iff (rst)
    (cw.ctrl.issue == mlp_pkg::ISS_BIAS) |-> inner == '0)
    else $error("inner counter not cleared at bias step");

endmodule

// ----- design/mlp_dpath.sv -----
// Datapath: weight, bias, sample and hidden memories, shared MAC pipeline,
// ReLU and Q8.8 saturation, output register. Depends on mlp_pkg.
module mlp_dpath #(
  parameter int IN_MAX  = 64,
  parameter int HID_MAX = 64,
  parameter int OUT_MAX = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_accept,
  input  logic [2:0]          opcode,
  input  logic [11:0]         index,
  input  logic signed [15:0]  value,
  input  mlp_pkg::ctrl_t      ctrl,
  input  logic [CNT_W-1:0]    inner,
  input  logic [CNT_W-1:0]    outer,
  input  logic [WA_W-1:0]     waddr,
  input  logic                out_stall,
  output logic                out_free,
  output logic                out_valid,
  output logic [2:0]          out_index,
  output logic signed [15:0]  out_value,
  output logic                last_of_run,
  output logic                clipped
);

  localparam int IN_AW  = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int HID_AW = (HID_MAX > 1) ? $clog2(HID_MAX) : 1;
  localparam int OUT_AW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int CNT_A  = (IN_AW > HID_AW) ? IN_AW : HID_AW;
  localparam int CNT_W  = (CNT_A > OUT_AW) ? CNT_A : OUT_AW;
  localparam int W1_DEPTH = IN_MAX * HID_MAX;
  localparam int W2_DEPTH = OUT_MAX * HID_MAX;
  localparam int W1_AW  = (W1_DEPTH > 1) ? $clog2(W1_DEPTH) : 1;
  localparam int W2_AW  = (W2_DEPTH > 1) ? $clog2(W2_DEPTH) : 1;
  localparam int WA_W   = (W1_AW > W2_AW) ? W1_AW : W2_AW;
  localparam int SUM_N  = (IN_MAX > HID_MAX) ? IN_MAX : HID_MAX;
  localparam int PROD_W = 2 * mlp_pkg::VAL_W;
  localparam int ACC_W  = PROD_W + 1 + $clog2(SUM_N);
  localparam int QW     = ACC_W - mlp_pkg::Q_FRAC;

  localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(32768);

  logic signed [15:0] w1_mem  [W1_DEPTH];
  logic signed [15:0] b1_mem  [HID_MAX];
  logic signed [15:0] w2_mem  [W2_DEPTH];
  logic signed [15:0] b2_mem  [OUT_MAX];
  logic signed [15:0] x_mem   [IN_MAX];
  logic signed [15:0] hid_mem [HID_MAX];

  logic signed [15:0] w1_q, b1_q, w2_q, b2_q, x_q, h_q;
  logic               wr_w1, wr_b1, wr_w2, wr_b2, wr_x;

  logic [1:0]               s1_issue;
  logic                     s1_layer2;
  logic [1:0]               s2_issue;
  logic signed [15:0]       mul_a, mul_b, bias;
  logic signed [PROD_W-1:0] prod, prod_next;
  logic signed [ACC_W-1:0]  acc;
  logic signed [QW-1:0]     qf;
  logic                     pos_ovf, neg_ovf;
  logic signed [15:0]       hid_w, out_w;
  logic                     hid_sat_now, out_sat_now;
  logic                     hsat;
  logic                     emit_go;

  always_comb begin
    wr_w1 = in_accept && (opcode == mlp_pkg::OP_W1) && (32'(index) < W1_DEPTH);
    wr_b1 = in_accept && (opcode == mlp_pkg::OP_B1) && (32'(index) < HID_MAX);
    wr_w2 = in_accept && (opcode == mlp_pkg::OP_W2) && (32'(index) < W2_DEPTH);
    wr_b2 = in_accept && (opcode == mlp_pkg::OP_B2) && (32'(index) < OUT_MAX);
    wr_x  = in_accept && (opcode == mlp_pkg::OP_SAMPLE) && (32'(index) < IN_MAX);
  end

  always_ff @(posedge clk) begin
    if (wr_w1) w1_mem[W1_AW'(index)] <= value;
    if (wr_b1) b1_mem[HID_AW'(index)] <= value;
    if (wr_w2) w2_mem[W2_AW'(index)] <= value;
    if (wr_b2) b2_mem[OUT_AW'(index)] <= value;
    if (wr_x)  x_mem[IN_AW'(index)] <= value;
    if (ctrl.wr_hid) hid_mem[outer[HID_AW-1:0]] <= hid_w;
  end

  always_ff @(posedge clk) begin
    w1_q <= w1_mem[waddr[W1_AW-1:0]];
    w2_q <= w2_mem[waddr[W2_AW-1:0]];
    x_q  <= x_mem[inner[IN_AW-1:0]];
    h_q  <= hid_mem[inner[HID_AW-1:0]];
    b1_q <= b1_mem[outer[HID_AW-1:0]];
    b2_q <= b2_mem[outer[OUT_AW-1:0]];
  end

  always_comb begin
    mul_a = s1_layer2 ? w2_q : w1_q;
    mul_b = s1_layer2 ? h_q : x_q;
    bias  = s1_layer2 ? b2_q : b1_q;
    if (s1_issue == mlp_pkg::ISS_BIAS) begin
      prod_next = PROD_W'(bias) <<< mlp_pkg::Q_FRAC;
    end else begin
      prod_next = mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_issue  <= mlp_pkg::ISS_NONE;
      s1_layer2 <= 1'b0;
      s2_issue  <= mlp_pkg::ISS_NONE;
    end else begin
      s1_issue  <= ctrl.issue;
      s1_layer2 <= ctrl.layer2;
      s2_issue  <= s1_issue;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (s2_issue == mlp_pkg::ISS_BIAS) begin
      acc <= ACC_W'(prod);
    end else if (s2_issue == mlp_pkg::ISS_MAC) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_comb begin
    qf      = acc[ACC_W-1:mlp_pkg::Q_FRAC];
    pos_ovf = (qf > Q_MAX);
    neg_ovf = (qf < Q_MIN);

    if (acc[ACC_W-1]) begin
      hid_w       = '0;
      hid_sat_now = 1'b0;
    end else if (pos_ovf) begin
      hid_w       = 16'sh7FFF;
      hid_sat_now = 1'b1;
    end else begin
      hid_w       = qf[15:0];
      hid_sat_now = 1'b0;
    end

    if (pos_ovf) begin
      out_w = 16'sh7FFF;
    end else if (neg_ovf) begin
      out_w = -16'sh8000;
    end else begin
      out_w = qf[15:0];
    end
    out_sat_now = pos_ovf || neg_ovf;

    out_free = !out_valid || !out_stall;
    emit_go  = ctrl.emit && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsat <= 1'b0;
    end else if (ctrl.clr_sat) begin
      hsat <= 1'b0;
    end else if (ctrl.wr_hid) begin
      hsat <= hsat || hid_sat_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_index   <= 3'(outer);
      out_value   <= out_w;
      last_of_run <= ctrl.last;
      clipped     <= hsat || out_sat_now;
    end
  end

  a_hid_nonneg: assert property (@(posedge clk) disable iff (rst) ctrl.wr_hid |-> !hid_w[15])
    else $error("negative hidden value after ReLU");
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (ctrl.emit || ctrl.wr_hid) |-> (s1_issue == mlp_pkg::ISS_NONE) &&
                                   (s2_issue == mlp_pkg::ISS_NONE))
    else $error("accumulator read before MAC pipeline drained");
  a_mac_order: assert property (@(posedge clk) disable iff (rst)
    (s2_issue == mlp_pkg::ISS_MAC) |-> ($past(s1_issue) == mlp_pkg::ISS_MAC))
    else $error("MAC stage out of step with read stage");

endmodule

// ----- design/two_layer_mlp_inference.sv -----
// Two-layer perceptron, ReLU hidden layer, signed Q8.8, one shared MAC.
// Loads and non-final sample elements are stored as they come, while idle.
// The final element starts a run through the MAC pipeline (read, multiply,
// accumulate) stepped by the microcode; no item is taken during the run.
// Synchronous reset: sizes return to 64/64/8, tables keep their contents.
module two_layer_mlp_inference #(
  parameter int IN_MAX  = 64,
  parameter int HID_MAX = 64,
  parameter int OUT_MAX = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic [11:0]        index,
  input  logic signed [15:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_index,
  output logic signed [15:0] out_value,
  output logic               last_of_run,
  output logic               clipped,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  localparam int IN_AW  = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int HID_AW = (HID_MAX > 1) ? $clog2(HID_MAX) : 1;
  localparam int OUT_AW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int CNT_A  = (IN_AW > HID_AW) ? IN_AW : HID_AW;
  localparam int CNT_W  = (CNT_A > OUT_AW) ? CNT_A : OUT_AW;
  localparam int W1_AW  = (IN_MAX * HID_MAX > 1) ? $clog2(IN_MAX * HID_MAX) : 1;
  localparam int W2_AW  = (OUT_MAX * HID_MAX > 1) ? $clog2(OUT_MAX * HID_MAX) : 1;
  localparam int WA_W   = (W1_AW > W2_AW) ? W1_AW : W2_AW;

  localparam logic [1:0] CFG_IN_SIZE  = 2'd0;
  localparam logic [1:0] CFG_HID_SIZE = 2'd1;
  localparam logic [1:0] CFG_OUT_SIZE = 2'd2;

  function automatic int clamp_last(input int v, input int max);
    int r;
    if (v < 1) r = 0;
    else if (v > max) r = max - 1;
    else r = v - 1;
    return r;
  endfunction

  logic [IN_AW-1:0]  in_last;
  logic [HID_AW-1:0] hid_last;
  logic [OUT_AW-1:0] out_last;
  logic              in_accept;
  logic              trig;
  logic              idle;
  logic              out_free;
  mlp_pkg::ctrl_t    ctrl;
  logic [CNT_W-1:0]  inner;
  logic [CNT_W-1:0]  outer;
  logic [WA_W-1:0]   waddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_last  <= IN_AW'(clamp_last(64, IN_MAX));
      hid_last <= HID_AW'(clamp_last(64, HID_MAX));
      out_last <= OUT_AW'(clamp_last(8, OUT_MAX));
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_SIZE:  in_last  <= IN_AW'(clamp_last(int'(cfg_data), IN_MAX));
        CFG_HID_SIZE: hid_last <= HID_AW'(clamp_last(int'(cfg_data), HID_MAX));
        CFG_OUT_SIZE: out_last <= OUT_AW'(clamp_last(int'(cfg_data[3:0]), OUT_MAX));
        default: ;
      endcase
    end
  end

  always_comb begin
    in_stall  = !idle;
    in_accept = in_valid && !in_stall;
    trig      = in_accept && (opcode == mlp_pkg::OP_SAMPLE) &&
                (32'(index) == 32'(in_last));
  end

  mlp_useq #(
    .IN_MAX  (IN_MAX),
    .HID_MAX (HID_MAX),
    .OUT_MAX (OUT_MAX)
  ) u_useq (
    .clk      (clk),
    .rst      (rst),
    .trig     (trig),
    .in_last  (in_last),
    .hid_last (hid_last),
    .out_last (out_last),
    .out_free (out_free),
    .idle     (idle),
    .ctrl     (ctrl),
    .inner    (inner),
    .outer    (outer),
    .waddr    (waddr)
  );

  mlp_dpath #(
    .IN_MAX  (IN_MAX),
    .HID_MAX (HID_MAX),
    .OUT_MAX (OUT_MAX)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .in_accept   (in_accept),
    .opcode      (opcode),
    .index       (index),
    .value       (value),
    .ctrl        (ctrl),
    .inner       (inner),
    .outer       (outer),
    .waddr       (waddr),
    .out_stall   (out_stall),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_index   (out_index),
    .out_value   (out_value),
    .last_of_run (last_of_run),
    .clipped     (clipped)
  );

endmodule
